[hw/rtl/srsm_pkg.sv]
package srsm_pkg;

    localparam int MAX_RUN    = 2;
    localparam int COORD_W    = 10;
    localparam int CHAN_W     = 8;
    localparam int CNT_W      = $clog2(MAX_RUN + 1);
    localparam int RUN_IW     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int FIFO_DEPTH = 2 ** $clog2(2 * MAX_RUN);
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAN_W-1:0] THRESH_RESET = 8'd30;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CHAN_W-1:0]  t_chan;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_pos;

endpackage

[hw/rtl/short_run_stroke_marker.sv]
// Short run stroke marker. Takes one RGB pixel per cycle in scan order while
// o_stall is low and finds runs of at most MAX_RUN pixels that start at a
// colour edge and end at the next edge; such a run's coordinates come out one
// mark per cycle while i_stall is low, the final mark of a burst flagged by
// o_last_mark. Colour compare, run tracking and the write of the marks into
// a FIFO_DEPTH-entry mark queue all happen in the cycle a pixel is taken, so
// pixels enter back to back at one per cycle while o_stall is low. The queue
// drains at one mark per cycle while i_stall is low; o_stall is high while
// the queue has fewer than MAX_RUN free entries, which only happens when the
// output side stalls or marks come in bursts. Line start pixels only load the
// previous colour; the run itself carries across line starts.
module short_run_stroke_marker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [srsm_pkg::CHAN_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_line_start,
    input  logic [srsm_pkg::CHAN_W-1:0] i_red,
    input  logic [srsm_pkg::CHAN_W-1:0] i_green,
    input  logic [srsm_pkg::CHAN_W-1:0] i_blue,
    input  logic [srsm_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [srsm_pkg::COORD_W-1:0] i_pixel_y,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [srsm_pkg::COORD_W-1:0] o_mark_x,
    output logic [srsm_pkg::COORD_W-1:0] o_mark_y,
    output logic                       o_last_mark
);
    import srsm_pkg::*;

    function automatic logic chan_over(input t_chan a, input t_chan b, input t_chan t);
        t_chan g;
        g = (a > b) ? (a - b) : (b - a);
        return g > t;
    endfunction

    t_chan               r_thresh;
    t_chan               r_prev_r, n_prev_r;
    t_chan               r_prev_g, n_prev_g;
    t_chan               r_prev_b, n_prev_b;
    logic                r_run_active, n_run_active;
    logic [CNT_W-1:0]    r_run_count, n_run_count;
    t_pos                r_run_pos [MAX_RUN];

    t_coord              r_fifo_x    [FIFO_DEPTH];
    t_coord              r_fifo_y    [FIFO_DEPTH];
    logic                r_fifo_last [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;

    logic                accept;
    logic                pop;
    logic                differ;
    logic [FILL_W-1:0]   push_n;
    logic [MAX_RUN-1:0]  lane_we;
    logic [MAX_RUN-1:0]  lane_last;
    logic                pos_we;
    logic [RUN_IW-1:0]   pos_idx;

    assign o_stall  = r_fill > FILL_W'(FIFO_DEPTH - MAX_RUN);
    assign o_valid  = r_fill != '0;
    assign accept   = i_valid && !o_stall;
    assign pop      = o_valid && !i_stall;

    assign o_mark_x    = r_fifo_x[r_rd_ptr];
    assign o_mark_y    = r_fifo_y[r_rd_ptr];
    assign o_last_mark = r_fifo_last[r_rd_ptr];

    assign differ = chan_over(r_prev_r, i_red,   r_thresh) ||
                    chan_over(r_prev_g, i_green, r_thresh) ||
                    chan_over(r_prev_b, i_blue,  r_thresh);

    always_comb begin
        n_prev_r     = r_prev_r;
        n_prev_g     = r_prev_g;
        n_prev_b     = r_prev_b;
        n_run_active = r_run_active;
        n_run_count  = r_run_count;
        push_n       = '0;
        lane_we      = '0;
        pos_we       = 1'b0;
        pos_idx      = '0;
        for (int j = 0; j < MAX_RUN; j++) begin
            lane_last[j] = (CNT_W'(j + 1) == r_run_count);
        end
        if (accept) begin
            n_prev_r = i_red;
            n_prev_g = i_green;
            n_prev_b = i_blue;
            if (!i_line_start) begin
                if (differ) begin
                    if (r_run_active) begin
                        for (int j = 0; j < MAX_RUN; j++) begin
                            lane_we[j] = CNT_W'(j) < r_run_count;
                        end
                        push_n = FILL_W'(r_run_count);
                    end
                    n_run_count  = CNT_W'(1);
                    n_run_active = 1'b1;
                    pos_we       = 1'b1;
                    pos_idx      = '0;
                end else if (r_run_active) begin
                    if (r_run_count == CNT_W'(MAX_RUN)) begin
                        // drop a run that grew too long
                        n_run_active = 1'b0;
                        n_run_count  = '0;
                    end else begin
                        n_run_count = r_run_count + CNT_W'(1);
                        pos_we      = 1'b1;
                        pos_idx     = r_run_count[RUN_IW-1:0];
                    end
                end
            end
        end
        n_fill   = r_fill + push_n - FILL_W'(pop);
        n_wr_ptr = r_wr_ptr + push_n[FIFO_AW-1:0];
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh     <= THRESH_RESET;
            r_prev_r     <= '0;
            r_prev_g     <= '0;
            r_prev_b     <= '0;
            r_run_active <= 1'b0;
            r_run_count  <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fill       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            r_prev_r     <= n_prev_r;
            r_prev_g     <= n_prev_g;
            r_prev_b     <= n_prev_b;
            r_run_active <= n_run_active;
            r_run_count  <= n_run_count;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_fill       <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_run_pos[pos_idx] <= '{y: i_pixel_y, x: i_pixel_x};
        end
        for (int j = 0; j < MAX_RUN; j++) begin
            if (lane_we[j]) begin
                r_fifo_x[r_wr_ptr + FIFO_AW'(j)]    <= r_run_pos[j].x;
                r_fifo_y[r_wr_ptr + FIFO_AW'(j)]    <= r_run_pos[j].y;
                r_fifo_last[r_wr_ptr + FIFO_AW'(j)] <= lane_last[j];
            end
        end
    end

endmodule

[hw/rtl/srsm_checker.sv]
module srsm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_line_start,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [srsm_pkg::COORD_W-1:0] o_mark_x,
    input logic [srsm_pkg::COORD_W-1:0] o_mark_y,
    input logic                         o_last_mark
);
    import srsm_pkg::*;

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output item dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_mark_x) && $stable(o_mark_y) && $stable(o_last_mark))
        else $error("stalled output item changed");

    a_burst_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_mark |=> o_valid)
        else $error("mark burst broken before its last mark");

    a_line_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_line_start && !o_valid |=> !o_valid)
        else $error("line start item produced a mark");

endmodule

bind short_run_stroke_marker srsm_checker u_srsm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_line_start (i_line_start),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_mark_x     (o_mark_x),
    .o_mark_y     (o_mark_y),
    .o_last_mark  (o_last_mark)
);
